FILE: sv/efl_alloc_pkg.sv
`timescale 1ns / 1ps

package efl_alloc_pkg;

    localparam int FREE_SLOTS = 16;
    localparam int SIZE_BITS  = 24;
    localparam int CNT_W      = $clog2(FREE_SLOTS + 1);
    localparam int END_W      = 34;

    localparam logic [63:0] GUARD_MAGIC  = 64'h0123_4567_89AB_CDEF;
    localparam logic [31:0] HEADER_BYTES = 32'd24;
    localparam logic [31:0] TAIL_BYTES   = 32'd8;

    localparam logic REG_HEAP_BASE  = 1'b0;
    localparam logic REG_HEAP_LIMIT = 1'b1;

    typedef enum logic [2:0] {
        STAT_REUSED  = 3'd0,
        STAT_NEW     = 3'd1,
        STAT_NOMEM   = 3'd2,
        STAT_FREED   = 3'd3,
        STAT_NULL    = 3'd4,
        STAT_CORRUPT = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_EVAL,
        FSM_COMMIT
    } fsm_t;

    typedef struct packed {
        logic [31:0]          addr;
        logic [SIZE_BITS-1:0] size;
    } efl_entry_t;

    typedef struct packed {
        logic load_new;
        logic shift;
    } efl_cell_ctl_t;

endpackage

FILE: sv/efl_cell.sv
`timescale 1ns / 1ps

module efl_cell
    import efl_alloc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [SIZE_BITS-1:0] req_size,
    input  logic                 valid,
    input  efl_cell_ctl_t        ctl,
    input  efl_entry_t           upper,
    input  efl_entry_t           new_entry,
    output efl_entry_t           entry,
    output logic                 match
);

    efl_entry_t entry_reg;
    efl_entry_t entry_next;
    logic       match_reg;
    logic       match_next;

    // new entry wins over a shift; otherwise hold
    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.load_new)
        begin
            entry_next = new_entry;
        end
        else if (ctl.shift)
        begin
            entry_next = upper;
        end
        match_next = valid && (entry_reg.size == req_size);
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    assign entry = entry_reg;
    assign match = match_reg;

endmodule

FILE: sv/efl_pick.sv
`timescale 1ns / 1ps

module efl_pick
    import efl_alloc_pkg::*;
(
    input  logic [FREE_SLOTS-1:0] match,
    input  efl_entry_t            entries [FREE_SLOTS],
    output logic                  found,
    output logic [31:0]           sel_addr,
    output logic [FREE_SLOTS-1:0] shift
);

    logic [FREE_SLOTS-1:0] sel;

    // highest matching slot is nearest the head
    for (genvar k = 0; k < FREE_SLOTS; k++)
    begin : g_sel
        localparam logic [FREE_SLOTS-1:0] LOW_MASK =
            {FREE_SLOTS{1'b1}} >> (FREE_SLOTS - 1 - k);
        assign sel[k]   = match[k] && !(|(match >> (k + 1)));
        assign shift[k] = |(sel & LOW_MASK);
    end

    always_comb
    begin
        sel_addr = '0;
        for (int k = 0; k < FREE_SLOTS; k++)
        begin
            sel_addr = sel_addr | (sel[k] ? entries[k].addr : 32'd0);
        end
    end

    assign found = |match;

endmodule

FILE: sv/exact_fit_free_list_allocator.sv
`timescale 1ns / 1ps
// A request beat is held through the evaluate state (a size compare registered in every
// free-list cell) and the commit state (which updates the chain and the break); a new
// beat may be accepted in the same cycle as the commit of the one before it.
// A stalled result holds the commit cycle until the result register drains.
// Reset (rst_n, async low): free list empty, heap_base 0, break 0, heap_limit all ones.
module exact_fit_free_list_allocator
    import efl_alloc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // request stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // [23:0] request_size, [55:24] address, [79:56] stored_size,
    // [143:80] header_guard, [207:144] tail_guard
    input  logic [207:0] s_tdata,
    // [0] action (0 allocate, 1 free)
    input  logic [0:0]   s_tuser,
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] block_address
    output logic [31:0]  m_tdata,
    // [2:0] status, [3] list_full
    output logic [3:0]   m_tuser,
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    // ---------------------------------------------------------------
    // Input beat fields
    // ---------------------------------------------------------------
    logic [23:0] in_req_size;
    logic [31:0] in_addr;
    logic [23:0] in_stored_size;
    logic [63:0] in_hguard;
    logic [63:0] in_tguard;

    assign in_req_size    = s_tdata[23:0];
    assign in_addr        = s_tdata[55:24];
    assign in_stored_size = s_tdata[79:56];
    assign in_hguard      = s_tdata[143:80];
    assign in_tguard      = s_tdata[207:144];

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    fsm_t state_reg, state_next;

    logic [31:0]      base_reg, base_next;
    logic [31:0]      limit_reg, limit_next;
    logic [31:0]      brk_reg, brk_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // request held for the evaluate and commit cycles
    logic                 action_reg;
    logic [SIZE_BITS-1:0] req_size_reg;
    logic [31:0]          addr_reg;
    logic [SIZE_BITS-1:0] stored_size_reg;
    logic                 guard_ok_reg;

    // evaluate-cycle results
    logic [END_W-1:0] end_reg, end_next;
    logic             nomem_reg, nomem_next;

    // result register
    logic        m_valid_reg, m_valid_next;
    logic [31:0] m_addr_reg, m_addr_next;
    status_t     m_status_reg, m_status_next;
    logic        m_full_reg, m_full_next;

    logic accept;
    logic commit;
    logic out_free;
    logic cfg_write;

    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign cfg_write = psel && penable && pwrite && pready;

    // ---------------------------------------------------------------
    // Cell chain: slot 0 is the oldest entry, slot count-1 the head
    // ---------------------------------------------------------------
    efl_entry_t            cell_entry [FREE_SLOTS];
    efl_cell_ctl_t         cell_ctl   [FREE_SLOTS];
    logic [FREE_SLOTS-1:0] cell_match;
    logic [FREE_SLOTS-1:0] cell_valid;
    logic [FREE_SLOTS-1:0] pick_shift;
    efl_entry_t            push_entry;
    logic                  found;
    logic [31:0]           sel_addr;
    logic                  do_remove;
    logic                  do_push;

    assign push_entry.addr = addr_reg;
    assign push_entry.size = stored_size_reg;

    for (genvar k = 0; k < FREE_SLOTS; k++)
    begin : g_cell
        efl_entry_t upper;

        if (k == FREE_SLOTS - 1)
        begin : g_top
            assign upper = '0;
        end
        else
        begin : g_mid
            assign upper = cell_entry[k + 1];
        end

        assign cell_valid[k]        = CNT_W'(k) < count_reg;
        assign cell_ctl[k].shift    = do_remove && pick_shift[k];
        assign cell_ctl[k].load_new = do_push && (count_reg == CNT_W'(k));

        efl_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .req_size  (req_size_reg),
            .valid     (cell_valid[k]),
            .ctl       (cell_ctl[k]),
            .upper     (upper),
            .new_entry (push_entry),
            .entry     (cell_entry[k]),
            .match     (cell_match[k])
        );
    end

    efl_pick u_pick (
        .match    (cell_match),
        .entries  (cell_entry),
        .found    (found),
        .sel_addr (sel_addr),
        .shift    (pick_shift)
    );

    // ---------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE:
            begin
                if (accept)
                begin
                    state_next = FSM_EVAL;
                end
            end
            FSM_EVAL:
            begin
                state_next = FSM_COMMIT;
            end
            FSM_COMMIT:
            begin
                if (out_free)
                begin
                    state_next = accept ? FSM_EVAL : FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // Sequencer: outputs (take a beat while idle, or in the same cycle as a commit)
    always_comb
    begin
        s_tready = 1'b0;
        commit   = 1'b0;
        unique case (state_reg)
            FSM_IDLE:
            begin
                s_tready = 1'b1;
            end
            FSM_EVAL:
            begin
                s_tready = 1'b0;
            end
            FSM_COMMIT:
            begin
                s_tready = out_free;
                commit   = out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Evaluate: bump address and limit check, computed without wrap
    // ---------------------------------------------------------------
    always_comb
    begin
        end_next = END_W'(brk_reg) + END_W'(req_size_reg)
                 + END_W'(HEADER_BYTES) + END_W'(TAIL_BYTES);
        nomem_next = end_next > END_W'(limit_reg);
    end

    // ---------------------------------------------------------------
    // Commit: update list, break and result register
    // ---------------------------------------------------------------
    always_comb
    begin
        do_remove     = 1'b0;
        do_push       = 1'b0;
        brk_next      = brk_reg;
        count_next    = count_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_addr_next   = m_addr_reg;
        m_status_next = m_status_reg;
        m_full_next   = m_full_reg;

        if (commit)
        begin
            m_valid_next = 1'b1;
            m_addr_next  = '0;
            m_full_next  = 1'b0;
            if (!action_reg)
            begin
                if (found)
                begin
                    do_remove     = 1'b1;
                    count_next    = count_reg - CNT_W'(1);
                    m_addr_next   = sel_addr;
                    m_status_next = STAT_REUSED;
                end
                else if (nomem_reg)
                begin
                    m_status_next = STAT_NOMEM;
                end
                else
                begin
                    brk_next      = end_reg[31:0];
                    m_addr_next   = brk_reg + HEADER_BYTES;
                    m_status_next = STAT_NEW;
                end
            end
            else
            begin
                if (addr_reg == 32'd0)
                begin
                    m_status_next = STAT_NULL;
                end
                else if (!guard_ok_reg)
                begin
                    m_status_next = STAT_CORRUPT;
                end
                else if (count_reg == CNT_W'(FREE_SLOTS))
                begin
                    // list full: drop the entry
                    m_status_next = STAT_FREED;
                    m_full_next   = 1'b1;
                end
                else
                begin
                    do_push       = 1'b1;
                    count_next    = count_reg + CNT_W'(1);
                    m_status_next = STAT_FREED;
                end
            end
        end

        // a base write restarts the break; the user must write it only while idle (not enforced here)
        if (cfg_write && (paddr[2] == REG_HEAP_BASE))
        begin
            brk_next = pwdata;
        end
    end

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    always_comb
    begin
        base_next  = base_reg;
        limit_next = limit_reg;
        if (cfg_write)
        begin
            unique case (paddr[2])
                REG_HEAP_BASE:  base_next  = pwdata;
                REG_HEAP_LIMIT: limit_next = pwdata;
                default:        base_next  = base_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_HEAP_BASE:  prdata = base_reg;
            REG_HEAP_LIMIT: prdata = limit_reg;
            default:        prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= FSM_IDLE;
            base_reg    <= '0;
            limit_reg   <= '1;
            brk_reg     <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            base_reg    <= base_next;
            limit_reg   <= limit_next;
            brk_reg     <= brk_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload: no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg      <= s_tuser[0];
            req_size_reg    <= SIZE_BITS'(in_req_size);
            addr_reg        <= in_addr;
            stored_size_reg <= SIZE_BITS'(in_stored_size);
            guard_ok_reg    <= (in_hguard == GUARD_MAGIC) && (in_tguard == GUARD_MAGIC);
        end
        if (state_reg == FSM_EVAL)
        begin
            end_reg   <= end_next;
            nomem_reg <= nomem_next;
        end
        m_addr_reg   <= m_addr_next;
        m_status_reg <= m_status_next;
        m_full_reg   <= m_full_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_addr_reg;
    assign m_tuser  = {m_full_reg, m_status_reg};

endmodule
